/* sv/micdir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micdir_pkg
// Shared constants, types and tables for the microphone direction-to-LED unit.
// ----------------------------------------------------------------------------
package micdir_pkg;

	// Frame and array geometry
	localparam int SAMPLES_PER_CHANNEL = 1024;
	localparam int MIC_COUNT           = 4;
	localparam int LED_COUNT           = 16;
	localparam int CORDIC_STEPS        = 16;

	localparam int FRAME_LEN = MIC_COUNT * SAMPLES_PER_CHANNEL;
	localparam int FRAME_W   = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int CH_W      = $clog2(MIC_COUNT);
	localparam int LED_W     = $clog2(LED_COUNT);
	localparam int LED_HALF  = LED_COUNT / 2;
	localparam int HALF_W    = $clog2(LED_HALF + 1);
	localparam int STEP_W    = $clog2(CORDIC_STEPS);

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int DIR_W    = 16;
	localparam int CORDIC_W = 32;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd400;
	localparam logic [SAMPLE_W-1:0] TRACK_MIN_RESET = 12'd4095;
	localparam logic [DIR_W-1:0]    HALF_TURN       = 16'h8000;
	localparam logic [7:0]          HUE_CAP         = 8'd175;

	// Reciprocal of 40 scaled by 2^19, exact for every 12-bit amplitude
	localparam logic [13:0] RECIP_40   = 14'd13108;
	localparam int          RECIP_SHIFT = 19;

	// Frame-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AMP,
		ST_CHECK,
		ST_CORDIC,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// Request into the shared CORDIC unit
	typedef struct packed {
		logic                       start;
		logic signed [SAMPLE_W:0]   x;
		logic signed [SAMPLE_W:0]   y;
	} cordic_req_t;

	// Result out of the shared CORDIC unit
	typedef struct packed {
		logic             done;
		logic [DIR_W-1:0] angle;
	} cordic_status_t;

	// Arctangent of 2^-k in binary angle units
	function automatic logic [DIR_W-1:0] atan_units(input logic [4:0] k);
		logic [DIR_W-1:0] v;
		case (k)
			5'd0:    v = 16'd8192;
			5'd1:    v = 16'd4836;
			5'd2:    v = 16'd2555;
			5'd3:    v = 16'd1297;
			5'd4:    v = 16'd651;
			5'd5:    v = 16'd326;
			5'd6:    v = 16'd163;
			5'd7:    v = 16'd81;
			5'd8:    v = 16'd41;
			5'd9:    v = 16'd20;
			5'd10:   v = 16'd10;
			5'd11:   v = 16'd5;
			5'd12:   v = 16'd3;
			5'd13:   v = 16'd1;
			5'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// Hue per ring distance, built at elaboration
	function automatic logic [(LED_HALF+1)*8-1:0] build_hue_table();
		logic [(LED_HALF+1)*8-1:0] t;
		int h;
		t = '0;
		for (int d = 0; d <= LED_HALF; d++) begin
			h = (255 * (LED_HALF - d)) / LED_HALF;
			if (h > 175)
				h = 175;
			t[d*8 +: 8] = 8'(h);
		end
		return t;
	endfunction

	localparam logic [(LED_HALF+1)*8-1:0] HUE_TABLE = build_hue_table();

endpackage

/* sv/mic_array_direction_to_led_ring_unit.sv */
`timescale 1ns / 1ps
// Throughput: one sample per cycle while a frame is being collected.
// After the last sample of a frame the input stalls through amplitude latching,
// the threshold check, the CORDIC run, scaling and the LED result sequence
// (which an output stall can hold); below threshold it stalls only through
// amplitude latching and the threshold check.
// Reset: asynchronous, active low; trackers, frame position and threshold reload.
// ----------------------------------------------------------------------------
// mic_array_direction_to_led_ring_unit
// Tracks per-channel peak-to-peak amplitude over a frame; above threshold it
// estimates direction by CORDIC atan2 and emits a hue/brightness result per LED.
// ----------------------------------------------------------------------------
module mic_array_direction_to_led_ring_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration
	input  logic                                   cfg_we,
	input  logic [micdir_pkg::SAMPLE_W-1:0]        cfg_wdata,
	// Sample stream
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [micdir_pkg::SAMPLE_W-1:0]        sample,
	// LED results
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [5:0]                             led_index,
	output logic [7:0]                             hue,
	output logic [6:0]                             brightness,
	output logic [micdir_pkg::DIR_W-1:0]           direction,
	output logic [micdir_pkg::SAMPLE_W-1:0]        peak_amplitude,
	output logic                                   last_led
);
	import micdir_pkg::*;

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] thr_q;
	logic [FRAME_W-1:0]  frame_pos_q;
	logic [SAMPLE_W-1:0] max_q [MIC_COUNT];
	logic [SAMPLE_W-1:0] min_q [MIC_COUNT];
	logic [SAMPLE_W-1:0] latch_q [MIC_COUNT];
	logic [CH_W-1:0]     ch_q;
	logic [LED_W-1:0]    led_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [DIR_W-1:0]    dir_q;
	logic [LED_W-1:0]    primary_q;
	logic [6:0]          bright_q;
	logic                out_valid_q;

	logic [5:0]          led_index_q;
	logic [7:0]          hue_q;
	logic [6:0]          brightness_q;
	logic [DIR_W-1:0]    direction_q;
	logic [SAMPLE_W-1:0] peak_amplitude_q;
	logic                last_led_q;

	logic                in_accept, frame_end, out_load, out_free;
	logic [CH_W-1:0]     cur_ch;
	logic [SAMPLE_W-1:0] amp, peak_next;
	cordic_req_t         creq;
	cordic_status_t      cstat;

	logic [DIR_W+LED_W-1:0]   dir_prod;
	logic [SAMPLE_W+13:0]     bright_prod;
	logic signed [LED_W+1:0]  dist_s;
	logic [LED_W+1:0]         dist_abs;
	logic [HALF_W-1:0]        dist_idx;
	logic [7:0]               hue_cur;

	// Shared CORDIC unit
	micdir_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.status (cstat)
	);

	assign in_accept = in_valid && !in_stall;
	assign cur_ch    = frame_pos_q[CH_W-1:0];
	assign frame_end = (frame_pos_q == FRAME_W'(FRAME_LEN - 1));
	assign out_free  = !out_valid_q || !out_stall;

	// Amplitude of the channel under the latch counter
	assign amp       = (max_q[ch_q] >= min_q[ch_q]) ? (max_q[ch_q] - min_q[ch_q]) : '0;
	assign peak_next = (ch_q == '0 || amp > peak_q) ? amp : peak_q;

	// Primary LED and brightness scaling
	assign dir_prod    = {{LED_W{1'b0}}, dir_q} * (DIR_W+LED_W)'(LED_COUNT);
	assign bright_prod = {14'b0, peak_q} * {12'b0, RECIP_40};

	// Wrapped ring distance from the primary LED and its hue
	always_comb begin
		dist_s = $signed({2'b0, led_q}) - $signed({2'b0, primary_q});
		if (dist_s < -$signed((LED_W+2)'(LED_HALF)))
			dist_s = dist_s + $signed((LED_W+2)'(LED_COUNT));
		else if (dist_s > $signed((LED_W+2)'(LED_HALF)))
			dist_s = dist_s - $signed((LED_W+2)'(LED_COUNT));
		dist_abs = dist_s[LED_W+1] ? (LED_W+2)'(-dist_s) : (LED_W+2)'(dist_s);
		if (dist_abs > (LED_W+2)'(LED_HALF))
			dist_abs = (LED_W+2)'(LED_HALF);
		dist_idx = dist_abs[HALF_W-1:0];
		hue_cur  = HUE_TABLE[{dist_idx, 3'b000} +: 8];
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d     = state_q;
		creq.start  = 1'b0;
		// Direction vector from opposite microphone pairs
		creq.x      = $signed({1'b0, latch_q[0]}) - $signed({1'b0, latch_q[2]});
		creq.y      = $signed({1'b0, latch_q[1]}) - $signed({1'b0, latch_q[3]});
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && frame_end)
					state_d = ST_AMP;
			end
			ST_AMP: begin
				if (ch_q == CH_W'(MIC_COUNT - 1))
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (peak_q > thr_q) begin
					creq.start = 1'b1;
					state_d    = ST_CORDIC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CORDIC: begin
				if (cstat.done)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (led_q == LED_W'(LED_COUNT - 1))
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Control registers, trackers and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THRESHOLD_RESET;
			frame_pos_q <= '0;
			ch_q        <= '0;
			led_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < MIC_COUNT; c++) begin
				max_q[c] <= '0;
				min_q[c] <= TRACK_MIN_RESET;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we)
				thr_q <= cfg_wdata;
			// Track extremes and advance the frame position
			if (in_accept) begin
				if (sample > max_q[cur_ch])
					max_q[cur_ch] <= sample;
				if (sample < min_q[cur_ch])
					min_q[cur_ch] <= sample;
				frame_pos_q <= frame_end ? '0 : frame_pos_q + 1'b1;
				ch_q        <= '0;
			end
			// Latch pass: restart each tracker once read
			if (state_q == ST_AMP) begin
				max_q[ch_q] <= '0;
				min_q[ch_q] <= TRACK_MIN_RESET;
				ch_q        <= ch_q + 1'b1;
			end
			if (state_q == ST_SCALE)
				led_q <= '0;
			else if (out_load)
				led_q <= led_q + 1'b1;
			// Output register: hold until taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_AMP) begin
			latch_q[ch_q] <= amp;
			peak_q        <= peak_next;
		end
		if (state_q == ST_CORDIC && cstat.done)
			dir_q <= cstat.angle + HALF_TURN;
		if (state_q == ST_SCALE) begin
			primary_q <= dir_prod[DIR_W+LED_W-1:DIR_W];
			bright_q  <= bright_prod[RECIP_SHIFT+6:RECIP_SHIFT];
		end
		if (out_load) begin
			led_index_q      <= 6'(led_q);
			hue_q            <= (hue_cur > HUE_CAP) ? HUE_CAP : hue_cur;
			brightness_q     <= bright_q;
			direction_q      <= dir_q;
			peak_amplitude_q <= peak_q;
			last_led_q       <= (led_q == LED_W'(LED_COUNT - 1));
		end
	end

	assign out_valid      = out_valid_q;
	assign led_index      = led_index_q;
	assign hue            = hue_q;
	assign brightness     = brightness_q;
	assign direction      = direction_q;
	assign peak_amplitude = peak_amplitude_q;
	assign last_led       = last_led_q;

endmodule

/* sv/micdir_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micdir_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle through a pair of
// barrel shifters and adders reused every step, returning the binary angle of (x, y).
// ----------------------------------------------------------------------------
module micdir_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  micdir_pkg::cordic_req_t     req,
	output micdir_pkg::cordic_status_t  status
);
	import micdir_pkg::*;

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic        [DIR_W-1:0]    z_q;
	logic        [STEP_W-1:0]   k_q;
	logic                       busy_q, done_q, zero_q;

	logic signed [CORDIC_W-1:0] x0, y0, dx, dy;
	logic                       y_pos, last_step;

	// Scale the inputs by 2^16
	assign x0 = {{(CORDIC_W-SAMPLE_W-17){req.x[SAMPLE_W]}}, req.x, 16'b0};
	assign y0 = {{(CORDIC_W-SAMPLE_W-17){req.y[SAMPLE_W]}}, req.y, 16'b0};

	// Shifters: floor shifts of the current vector
	assign dx        = y_q >>> k_q;
	assign dy        = x_q >>> k_q;
	assign y_pos     = !y_q[CORDIC_W-1] && (y_q != '0);
	assign last_step = (k_q == STEP_W'(CORDIC_STEPS - 1));

	// Control: load, iterate, signal completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: fold into the right half plane, then rotate toward y = 0
	always_ff @(posedge clk) begin
		if (req.start) begin
			zero_q <= (req.x == '0) && (req.y == '0);
			if (req.x[SAMPLE_W]) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= HALF_TURN;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_units(5'(k_q));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_units(5'(k_q));
			end
		end
	end

	assign status = {done_q, (zero_q ? {DIR_W{1'b0}} : z_q)};

endmodule

/* bench/mic_array_direction_to_led_ring_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_array_direction_to_led_ring_unit_tb
// Streams whole frames of interleaved microphone samples into the unit,
// rewrites the amplitude threshold between frames, and checks every LED
// result against a frame-level prediction of amplitudes, angle and hue.
// ----------------------------------------------------------------------------
module mic_array_direction_to_led_ring_unit_tb;
	import micdir_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_LEN   = 6;
	localparam int IDLE_PCT    = 28;
	localparam int SETTLE      = MIC_COUNT + CORDIC_STEPS + LED_COUNT + 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_ROWS      = 14;

	// Arctangent of 2^-k in 1/65536 turn
	localparam int ARCTAN_STEP [24] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0
	};

	typedef logic [MIC_COUNT-1:0][SAMPLE_W-1:0] mic_word_t;

	typedef struct {
		logic [5:0]          led;
		logic [7:0]          hue;
		logic [6:0]          bright;
		logic [DIR_W-1:0]    dir;
		logic [SAMPLE_W-1:0] peak;
		logic                last;
	} led_result_t;

	// One directed frame: optional threshold write, a common floor and
	// per-mic swing (listed mic 3 down to mic 0); pinned rows carry the
	// frame outcome typed in directly
	typedef struct {
		logic                set_thr;
		logic [SAMPLE_W-1:0] thr;
		logic [SAMPLE_W-1:0] base;
		mic_word_t           amp;
		logic                pinned;
		logic                pin_emit;
		logic [DIR_W-1:0]    pin_dir;
		logic [SAMPLE_W-1:0] pin_peak;
		logic [6:0]          pin_bright;
	} frame_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [SAMPLE_W-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [5:0]          led_index;
	logic [7:0]          hue;
	logic [6:0]          brightness;
	logic [DIR_W-1:0]    direction;
	logic [SAMPLE_W-1:0] peak_amplitude;
	logic                last_led;

	// Shadow of the unit's state
	logic [SAMPLE_W-1:0] thr_shadow;
	logic [SAMPLE_W-1:0] trk_max [MIC_COUNT];
	logic [SAMPLE_W-1:0] trk_min [MIC_COUNT];
	int unsigned         frame_pos;

	led_result_t pending_leds [$];
	frame_row_t  cur_row;
	bit          row_typed = 1'b0;
	bit          quiet = 1'b0;

	int error_count = 0;
	int cycle_count = 0;
	int samples_sent = 0;
	int frames_done = 0;
	int frames_lit = 0;
	int leds_checked = 0;

	frame_row_t plan [N_ROWS] = '{
		// dark frame after reset, default threshold
		'{1'b0, 12'd0, 12'd2048, {12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, 1'b0, 16'h0000, 12'd0, 7'd0},
		// peak equal to the default threshold stays dark
		'{1'b0, 12'd0, 12'd0, {12'd0, 12'd0, 12'd0, 12'd400},
			1'b1, 1'b0, 16'h0000, 12'd0, 7'd0},
		// balanced array: zero vector points at half a turn
		'{1'b0, 12'd0, 12'd100, {12'd1000, 12'd1000, 12'd1000, 12'd1000},
			1'b1, 1'b1, 16'h8000, 12'd1000, 7'd25},
		// one step over threshold, mic 0 only
		'{1'b0, 12'd0, 12'd0, {12'd0, 12'd0, 12'd0, 12'd401},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// negative X
		'{1'b0, 12'd0, 12'd0, {12'd0, 12'd3000, 12'd0, 12'd100},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// positive Y
		'{1'b0, 12'd0, 12'd500, {12'd0, 12'd0, 12'd2000, 12'd0},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// negative Y
		'{1'b0, 12'd0, 12'd500, {12'd2000, 12'd0, 12'd0, 12'd50},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// full-scale swing on mic 0
		'{1'b0, 12'd0, 12'd0, {12'd0, 12'd0, 12'd0, 12'd4095},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// zero threshold, flat signal stays dark
		'{1'b1, 12'd0, 12'd1234, {12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, 1'b0, 16'h0000, 12'd0, 7'd0},
		// zero threshold, one-count swing lights the ring
		'{1'b0, 12'd0, 12'd0, {12'd1, 12'd1, 12'd1, 12'd1},
			1'b1, 1'b1, 16'h8000, 12'd1, 7'd0},
		// maximum threshold cannot be exceeded
		'{1'b1, 12'd4095, 12'd0, {12'd4095, 12'd0, 12'd4095, 12'd0},
			1'b1, 1'b0, 16'h0000, 12'd0, 7'd0},
		// back to default level, negative X on the axis
		'{1'b1, 12'd400, 12'd0, {12'd0, 12'd1000, 12'd0, 12'd0},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// positive X on the axis
		'{1'b0, 12'd0, 12'd0, {12'd1000, 12'd0, 12'd1000, 12'd3000},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0},
		// all mics near full scale, unequal
		'{1'b0, 12'd0, 12'd0, {12'd4000, 12'd3500, 12'd4095, 12'd3900},
			1'b0, 1'b0, 16'h0000, 12'd0, 7'd0}
	};

	mic_array_direction_to_led_ring_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.led_index      (led_index),
		.hue            (hue),
		.brightness     (brightness),
		.direction      (direction),
		.peak_amplitude (peak_amplitude),
		.last_led       (last_led)
	);

	always #CLK_HALF clk = ~clk;

	// Vectoring CORDIC on amplitude differences, result in 1/65536 turn
	function automatic logic [DIR_W-1:0] arrival_angle(input longint xin, input longint yin);
		longint           x;
		longint           y;
		longint           dx;
		longint           dy;
		logic [DIR_W-1:0] z;
		if (xin == 0 && yin == 0)
			return '0;
		x = xin * 65536;
		y = yin * 65536;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + DIR_W'(ARCTAN_STEP[k]);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - DIR_W'(ARCTAN_STEP[k]);
			end
		end
		return z;
	endfunction

	// Hue falls off with wrapped ring distance from the primary LED
	function automatic logic [7:0] ring_hue(input int led, input int primary);
		int half;
		int d;
		int ring_dist;
		int h;
		half = LED_COUNT / 2;
		d = led - primary;
		if (d < -half)
			d += LED_COUNT;
		else if (d > half)
			d -= LED_COUNT;
		ring_dist = (d < 0) ? -d : d;
		if (ring_dist > half)
			ring_dist = half;
		h = (255 * (half - ring_dist)) / half;
		if (h > 175)
			h = 175;
		return 8'(h);
	endfunction

	// Queue one full run of LED results for a lit frame
	function automatic void queue_ring(input logic [DIR_W-1:0] dir,
			input logic [SAMPLE_W-1:0] peak, input logic [6:0] bright);
		led_result_t r;
		int          primary;
		primary = int'((32'(dir) * LED_COUNT) >> 16) % LED_COUNT;
		for (int i = 0; i < LED_COUNT; i++) begin
			r.led    = 6'(i);
			r.hue    = ring_hue(i, primary);
			r.bright = bright;
			r.dir    = dir;
			r.peak   = peak;
			r.last   = (i == LED_COUNT - 1);
			pending_leds.push_back(r);
		end
		frames_lit++;
	endfunction

	// Advance the tracker shadow by one accepted sample
	function automatic void track_sample(input logic [SAMPLE_W-1:0] s);
		int                  ch;
		logic [SAMPLE_W-1:0] amp [MIC_COUNT];
		logic [SAMPLE_W-1:0] peak;
		logic [DIR_W-1:0]    dir;
		ch = int'(frame_pos % MIC_COUNT);
		if (s > trk_max[ch])
			trk_max[ch] = s;
		if (s < trk_min[ch])
			trk_min[ch] = s;
		samples_sent++;
		if (frame_pos + 1 < FRAME_LEN) begin
			frame_pos++;
			return;
		end
		frame_pos = 0;
		frames_done++;
		peak = '0;
		for (int c = 0; c < MIC_COUNT; c++) begin
			amp[c] = (trk_max[c] >= trk_min[c]) ? trk_max[c] - trk_min[c] : '0;
			if (amp[c] > peak)
				peak = amp[c];
			trk_max[c] = '0;
			trk_min[c] = TRACK_MIN_RESET;
		end
		if (row_typed) begin
			if (cur_row.pin_emit)
				queue_ring(cur_row.pin_dir, cur_row.pin_peak, cur_row.pin_bright);
		end else if (peak > thr_shadow) begin
			dir = arrival_angle(longint'(amp[0]) - longint'(amp[2]),
				longint'(amp[1]) - longint'(amp[3])) + HALF_TURN;
			queue_ring(dir, peak, 7'(peak / 40));
		end
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		error_count++;
		$display("mismatch on %s: got %0d, expected %0d (LED result %0d, t=%0t)",
			field, got, want, leds_checked, $realtime);
	endtask

	// Hold until every expected LED result has come out
	task automatic wait_for_drain();
		while (pending_leds.size() != 0)
			@(negedge clk);
	endtask

	// Offer one sample, with random gaps; return at the falling edge after acceptance
	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_sample(s);
		@(negedge clk);
	endtask

	// Write the threshold once the unit has gone idle
	task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		thr_shadow = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stream one frame: floor first, then peak, then samples within the swing (or random noise)
	task automatic send_frame(input mic_word_t lo, input mic_word_t amp, input bit noise);
		int                  ch;
		int                  per;
		logic [SAMPLE_W-1:0] s;
		for (int k = 0; k < FRAME_LEN; k++) begin
			ch  = k % MIC_COUNT;
			per = k / MIC_COUNT;
			if (noise)
				s = SAMPLE_W'($urandom_range(4095));
			else if (per == 0)
				s = lo[ch];
			else if (per == 1)
				s = lo[ch] + amp[ch];
			else
				s = lo[ch] + SAMPLE_W'($urandom_range(amp[ch]));
			push_sample(s);
		end
	endtask

	// Drive output stall at random, none during the quiet stretch
	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

	// Check each accepted LED result against the oldest expectation
	always @(posedge clk) begin
		led_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_leds.size() == 0) begin
				report_mismatch("unexpected result, led_index", led_index, -1);
			end else begin
				want = pending_leds.pop_front();
				if (led_index !== want.led)
					report_mismatch("led_index", led_index, want.led);
				if (hue !== want.hue)
					report_mismatch("hue", hue, want.hue);
				if (brightness !== want.bright)
					report_mismatch("brightness", brightness, want.bright);
				if (direction !== want.dir)
					report_mismatch("direction", direction, want.dir);
				if (peak_amplitude !== want.peak)
					report_mismatch("peak_amplitude", peak_amplitude, want.peak);
				if (last_led !== want.last)
					report_mismatch("last_led", last_led, want.last);
			end
			leds_checked++;
		end
	end

	// Bound the run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, pending_leds.size());
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		mic_word_t lo;
		mic_word_t amp;
		bit        noise;
		int        rnd_frames;
		int        lit_start;
		thr_shadow = THRESHOLD_RESET;
		frame_pos  = 0;
		for (int c = 0; c < MIC_COUNT; c++) begin
			trk_max[c] = '0;
			trk_min[c] = TRACK_MIN_RESET;
		end
		repeat (RESET_LEN) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames from the table
		for (int r = 0; r < N_ROWS; r++) begin
			if (plan[r].set_thr)
				write_threshold(plan[r].thr);
			cur_row   = plan[r];
			row_typed = plan[r].pinned;
			send_frame({MIC_COUNT{plan[r].base}}, plan[r].amp, 1'b0);
		end
		row_typed = 1'b0;

		// Random frames: at least 4, and more until 48 LED results are due or 10 frames
		rnd_frames = 0;
		lit_start  = frames_lit;
		while (rnd_frames < 4 ||
				((frames_lit - lit_start) * LED_COUNT < 48 && rnd_frames < 10)) begin
			if (rnd_frames == 0 || $urandom_range(2) == 0)
				write_threshold(SAMPLE_W'($urandom_range(1500)));
			noise = ($urandom_range(9) < 3);
			for (int c = 0; c < MIC_COUNT; c++) begin
				amp[c] = SAMPLE_W'($urandom_range(4095));
				lo[c]  = SAMPLE_W'($urandom_range(4095 - amp[c]));
			end
			quiet = (rnd_frames == 1);
			send_frame(lo, amp, noise);
			quiet = 1'b0;
			rnd_frames++;
		end

		// Drain and let the unit settle
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d frames (%0d lit, %0d dark) from %0d samples,",
			frames_done, frames_lit, frames_done - frames_lit, samples_sent);
		$display("%0d LED results checked, thresholds from 0 to 4095, %0d mismatches",
			leds_checked, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
sv/micdir_pkg.sv
sv/micdir_cordic.sv
sv/mic_array_direction_to_led_ring_unit.sv
bench/mic_array_direction_to_led_ring_unit_tb.sv
